// ===== src/keyboard_event_queue_core_macros.svh =====
// assertion macros for the keyboard event queue core
`ifndef KEYBOARD_EVENT_QUEUE_CORE_MACROS_SVH
`define KEYBOARD_EVENT_QUEUE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define KBQ_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("kbq assertion failed");

`define KBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kbq assertion failed");

`else

`define KBQ_ASSERT(label, clk, rst, expr)

`define KBQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/kbq_pkg.sv =====
// shared constants, types and helpers for the keyboard event queue
package kbq_pkg;

   localparam int QUEUE_SLOTS = 16;
   localparam int PTR_W       = $clog2(QUEUE_SLOTS);

   localparam logic [1:0] KIND_KEY  = 2'd0;
   localparam logic [1:0] KIND_TAKE = 2'd1;
   localparam logic [1:0] KIND_LED  = 2'd2;

   localparam logic [7:0] UP_FLAG = 8'h80;
   localparam logic [7:0] NO_CODE = 8'hFF;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [7:0]       code_type;

   typedef struct packed {
      logic    en;
      ptr_type addr0;
      ptr_type addr1;
   } ring_rd_type;

   typedef struct packed {
      logic     en;
      ptr_type  addr;
      code_type data;
   } ring_wr_type;

   function automatic ptr_type advance(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(QUEUE_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== src/keyboard_event_queue_core.sv =====
// keyboard event queue top level: pointer control, result register, assertions
// a result is registered and appears in the cycle after its transaction is accepted
// throughput: one transaction per cycle unless req_stall holds it, limited by the single result register
// req_stall is high only while a result is held and rsp_stall is high
// reset clears pointers, service request, led register and result valid
// ring contents are not cleared; entries reach a result only after being written
`include "keyboard_event_queue_core_macros.svh"

module keyboard_event_queue_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_key_code,
   input  logic       req_key_pressed,
   input  logic [7:0] req_led_bits,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_accepted,
   output logic [7:0] rsp_first_code,
   output logic [7:0] rsp_second_code,
   output logic       rsp_service_request,
   output logic [7:0] rsp_led_value
);
   import kbq_pkg::*;

   ptr_type     wr_ptr_ff, wr_ptr_in;
   ptr_type     rd_ptr_ff, rd_ptr_in;
   logic        flag_ff, flag_in;
   logic [7:0]  led_ff, led_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        accepted_ff, accepted_in;
   logic [1:0]  count_ff, count_in;
   logic        srq_ff;
   logic [7:0]  led_out_ff;

   logic        take;
   ptr_type     wr_next, rd_next1, rd_next2;
   logic        full, empty, single;
   ring_wr_type ring_wr;
   ring_rd_type ring_rd;
   code_type    rd_data0, rd_data1;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;

   assign wr_next  = advance(wr_ptr_ff);
   assign rd_next1 = advance(rd_ptr_ff);
   assign rd_next2 = advance(rd_next1);
   assign full     = (wr_next == rd_ptr_ff);
   assign empty    = (rd_ptr_ff == wr_ptr_ff);
   assign single   = (rd_next1 == wr_ptr_ff);

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      flag_in      = flag_ff;
      led_in       = led_ff;
      accepted_in  = 1'b1;
      count_in     = 2'd0;
      ring_wr.en   = 1'b0;
      ring_wr.addr = wr_ptr_ff;
      ring_wr.data = req_key_pressed ? (req_key_code & ~UP_FLAG) : (req_key_code | UP_FLAG);
      ring_rd.en   = 1'b0;
      ring_rd.addr0 = rd_ptr_ff;
      ring_rd.addr1 = rd_next1;
      if (take) begin
         case (req_kind)
            KIND_KEY: begin
               if (full) begin
                  accepted_in = 1'b0;
               end else begin
                  ring_wr.en = 1'b1;
                  wr_ptr_in  = wr_next;
                  flag_in    = 1'b1;
               end
            end
            KIND_TAKE: begin
               ring_rd.en = 1'b1;
               if (empty) begin
                  count_in = 2'd0;
                  flag_in  = 1'b0;
               end else if (single) begin
                  count_in  = 2'd1;
                  rd_ptr_in = rd_next1;
                  flag_in   = 1'b0;
               end else begin
                  count_in  = 2'd2;
                  rd_ptr_in = rd_next2;
                  flag_in   = (rd_next2 != wr_ptr_ff);
               end
            end
            KIND_LED: begin
               led_in = req_led_bits;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = take | (rsp_valid_ff & rsp_stall);

   kbq_ring u_ring (
      .clock    (clock),
      .wr       (ring_wr),
      .rd       (ring_rd),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         flag_ff      <= 1'b0;
         led_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         flag_ff      <= flag_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         accepted_ff <= accepted_in;
         count_ff    <= count_in;
         srq_ff      <= flag_in;
         led_out_ff  <= led_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = accepted_ff;
   assign rsp_first_code      = (count_ff != 2'd0) ? rd_data0 : NO_CODE;
   assign rsp_second_code     = (count_ff == 2'd2) ? rd_data1 : NO_CODE;
   assign rsp_service_request = srq_ff;
   assign rsp_led_value       = led_out_ff;

   `KBQ_ASSERT(a_flag_tracks_fill, clock, reset, flag_ff == (rd_ptr_ff != wr_ptr_ff))
   `KBQ_ASSERT_NEXT(a_full_drop_holds_ptr, clock, reset, take && req_kind == KIND_KEY && full, wr_ptr_ff == $past(wr_ptr_ff) && !rsp_accepted)
   `KBQ_ASSERT_NEXT(a_take_gives_result, clock, reset, take, rsp_valid_ff)

endmodule

// ===== src/kbq_ring.sv =====
// code ring storage: one write port, two registered read ports
module kbq_ring (
   input  logic                 clock,
   input  kbq_pkg::ring_wr_type wr,
   input  kbq_pkg::ring_rd_type rd,
   output kbq_pkg::code_type    rd_data0,
   output kbq_pkg::code_type    rd_data1
);
   import kbq_pkg::*;

   code_type ring_ff [QUEUE_SLOTS];
   code_type data0_ff;
   code_type data1_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ring_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         data0_ff <= ring_ff[rd.addr0];
         data1_ff <= ring_ff[rd.addr1];
      end
   end

   assign rd_data0 = data0_ff;
   assign rd_data1 = data1_ff;

endmodule

// ===== sim/kbq_tb_pkg.sv =====
// scoreboard for the keyboard event queue: ring predictor and response checks
package kbq_tb_pkg;
   import kbq_pkg::*;

   typedef struct packed {
      logic     accepted;
      code_type first_code;
      code_type second_code;
      logic     service_request;
      code_type led_value;
   } queue_report_type;

   class key_queue_scoreboard;
      code_type         ring [QUEUE_SLOTS];
      int unsigned      head;
      int unsigned      tail;
      logic             request_flag;
      code_type         leds;
      queue_report_type awaited [$];
      int               errors;
      int               keys_stored;
      int               keys_dropped;
      int               takes;
      int               led_writes;
      int               unused_kinds;
      int               reports_checked;

      function new();
         head = 0;
         tail = 0;
         request_flag = 1'b0;
         leds = '0;
         errors = 0;
         keys_stored = 0;
         keys_dropped = 0;
         takes = 0;
         led_writes = 0;
         unused_kinds = 0;
         reports_checked = 0;
      endfunction

      function int unsigned next_slot(int unsigned p);
         return (p + 1) % QUEUE_SLOTS;
      endfunction

      function void note_request(logic [1:0] kind, code_type key_code, logic key_pressed,
                                 code_type led_bits);
         queue_report_type r;
         r.accepted = 1'b1;
         r.first_code = NO_CODE;
         r.second_code = NO_CODE;
         case (kind)
            KIND_KEY: begin
               if (next_slot(tail) == head) begin
                  r.accepted = 1'b0;
                  keys_dropped++;
               end else begin
                  ring[tail] = key_pressed ? (key_code & ~UP_FLAG) : (key_code | UP_FLAG);
                  tail = next_slot(tail);
                  request_flag = 1'b1;
                  keys_stored++;
               end
            end
            KIND_TAKE: begin
               if (head != tail) begin
                  r.first_code = ring[head];
                  head = next_slot(head);
                  if (head != tail) begin
                     r.second_code = ring[head];
                     head = next_slot(head);
                  end
               end
               request_flag = (head != tail);
               takes++;
            end
            KIND_LED: begin
               leds = led_bits;
               led_writes++;
            end
            default: begin
               unused_kinds++;
            end
         endcase
         r.service_request = request_flag;
         r.led_value = leds;
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("rsp_%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(queue_report_type got);
         queue_report_type want;
         if (awaited.size() == 0) begin
            $error("response transaction with nothing outstanding");
            errors++;
            return;
         end
         want = awaited.pop_front();
         reports_checked++;
         compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
         compare_field("first_code", want.first_code, got.first_code);
         compare_field("second_code", want.second_code, got.second_code);
         compare_field("service_request", 8'(want.service_request), 8'(got.service_request));
         compare_field("led_value", want.led_value, got.led_value);
      endfunction
   endclass

endpackage

// ===== sim/keyboard_event_queue_core_tb.sv =====
// testbench top for the keyboard event queue core: directed and random traffic, scoreboard
module keyboard_event_queue_core_tb;
   import kbq_pkg::*;
   import kbq_tb_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int TYPING   = 0;
   localparam int DRAINING = 1;
   localparam int MIXED    = 2;

   localparam int RANDOM_ITEMS    = 1700;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PRESSURE_ITEMS  = 40;
   localparam int IDLE_LIMIT      = 3000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = '0;
   logic [7:0] req_key_code = '0;
   logic       req_key_pressed = 1'b0;
   logic [7:0] req_led_bits = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_accepted;
   logic [7:0] rsp_first_code;
   logic [7:0] rsp_second_code;
   logic       rsp_service_request;
   logic [7:0] rsp_led_value;

   key_queue_scoreboard board = new();

   bit quiet = 1'b0;
   int hold_request = 0;
   int pressure_items = 0;

   keyboard_event_queue_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_key_code        (req_key_code),
      .req_key_pressed     (req_key_pressed),
      .req_led_bits        (req_led_bits),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_first_code      (rsp_first_code),
      .rsp_second_code     (rsp_second_code),
      .rsp_service_request (rsp_service_request),
      .rsp_led_value       (rsp_led_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [1:0] pick_kind(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         TYPING: begin
            if (roll < 80) return KIND_KEY;
            if (roll < 95) return KIND_TAKE;
            if (roll < 99) return KIND_LED;
            return KIND_UNUSED;
         end
         DRAINING: begin
            if (roll < 70) return KIND_TAKE;
            if (roll < 95) return KIND_KEY;
            return KIND_LED;
         end
         default: begin
            if (roll < 45) return KIND_KEY;
            if (roll < 80) return KIND_TAKE;
            if (roll < 95) return KIND_LED;
            return KIND_UNUSED;
         end
      endcase
   endfunction

   task automatic send_item(input logic [1:0] kind, input code_type code, input logic down,
                            input code_type leds);
      int gap;
      if (pressure_items > 0) begin
         gap = 0;
         pressure_items--;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_key_code    <= code;
      req_key_pressed <= down;
      req_led_bits    <= leds;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, code, down, leds);
   endtask

   task automatic run_directed();
      send_item(KIND_TAKE, 8'h00, 1'b0, 8'h00);
      send_item(KIND_LED, 8'h00, 1'b0, 8'hFF);
      send_item(KIND_LED, 8'hFF, 1'b1, 8'h00);
      send_item(KIND_KEY, 8'h00, 1'b1, 8'hFF);
      send_item(KIND_KEY, 8'hFF, 1'b0, 8'h00);
      send_item(KIND_KEY, 8'hFF, 1'b1, 8'h5A);
      // two codes popped, one left behind
      send_item(KIND_TAKE, 8'hFF, 1'b1, 8'hFF);
      send_item(KIND_TAKE, 8'h80, 1'b0, 8'h00);
      send_item(KIND_UNUSED, 8'hFF, 1'b1, 8'hA5);
      send_item(KIND_LED, 8'h3C, 1'b0, 8'hA5);
      // fill the ring; the last key event is dropped
      for (int n = 0; n < QUEUE_SLOTS; n++) begin
         send_item(KIND_KEY, 8'(n * 17), n[0], 8'(~n));
      end
      send_item(KIND_TAKE, 8'h00, 1'b0, 8'h00);
   endtask

   task automatic run_random();
      int sent;
      int mode;
      int chunk;
      bit pressure_done;
      sent = 0;
      pressure_done = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(TYPING, MIXED);
         quiet = ($urandom_range(0, 4) == 0);
         chunk = $urandom_range(5, 40);
         for (int k = 0; k < chunk && sent < RANDOM_ITEMS; k++) begin
            if (!pressure_done && sent >= RANDOM_ITEMS / 2) begin
               quiet = 1'b0;
               hold_request = HOLD_OFF_CYCLES;
               pressure_items = PRESSURE_ITEMS;
               pressure_done = 1'b1;
            end
            send_item(pick_kind(mode), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   initial begin : response_side
      int stall_left;
      queue_report_type seen;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen.accepted = rsp_accepted;
            seen.first_code = rsp_first_code;
            seen.second_code = rsp_second_code;
            seen.service_request = rsp_service_request;
            seen.led_value = rsp_led_value;
            board.check_response(seen);
         end
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("keyboard_event_queue_core_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d key events stored, %0d dropped on a full ring, %0d report takes",
               board.keys_stored, board.keys_dropped, board.takes);
      $display("plus %0d led writes and %0d unused-kind items; %0d responses, %0d mismatches",
               board.led_writes, board.unused_kinds, board.reports_checked, board.errors);
      if (board.errors == 0) begin
         $display("keyboard_event_queue_core_tb: PASS");
      end else begin
         $display("keyboard_event_queue_core_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/kbq_pkg.sv
src/kbq_ring.sv
src/keyboard_event_queue_core.sv
sim/kbq_tb_pkg.sv
sim/keyboard_event_queue_core_tb.sv
